FILE: src/rqs_pkg.sv
// ----------------------------------------------------------------------------
// rqs_pkg: run queue shared definitions
// types, codes and defaults used by the run queue cells and top level
// ----------------------------------------------------------------------------
package rqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int AGE_W       = 32;
    localparam int TAG_W       = 8;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int OUT_CNT_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_STEAL   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // one stored task entry
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             runnable;
        logic             pinned;
        logic             in_exec;
        logic [AGE_W-1:0] age;
    } t_entry;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             capture;
        logic             remove;
        logic             steal;
        logic             nonexec;
        logic [AGE_W-1:0] victim_age;
    } t_cell_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [TAG_W-1:0] task_tag;
        logic             is_runnable;
        logic             is_pinned;
        logic             is_in_exec;
        logic [AGE_W-1:0] age_cycles;
        logic             allow_nonexec;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [TAG_W-1:0]     removed_tag;
        logic [AGE_W-1:0]     removed_age;
        logic [OUT_CNT_W-1:0] stealable_count;
        logic [OUT_CNT_W-1:0] occupancy;
    } t_out_item;

endpackage

FILE: src/rqs_stream_if.sv
// ----------------------------------------------------------------------------
// rqs_stream_if: valid/ready stream channel
// carries one payload per transfer, source drives valid and payload
// ----------------------------------------------------------------------------
interface rqs_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/rqs_cell.sv
// ----------------------------------------------------------------------------
// rqs_cell: one run queue slot
// holds an entry, judges it for steal and takes its neighbor's entry on removal
// ----------------------------------------------------------------------------
module rqs_cell (
    input  logic              i_clk,
    input  rqs_pkg::t_cell_ctl i_ctl,
    input  logic              i_occupied,
    input  logic              i_head,
    input  logic              i_write,
    input  rqs_pkg::t_entry   i_new,
    input  rqs_pkg::t_entry   i_next,
    input  logic              i_found,
    output logic              o_found,
    output logic              o_take,
    output logic              o_any,
    output rqs_pkg::t_entry   o_entry
);

    rqs_pkg::t_entry r_entry;
    rqs_pkg::t_entry n_entry;
    logic            r_age_ok;
    logic            w_hit;
    logic            w_sel;

    // age test is taken when the request is accepted
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_age_ok <= (r_entry.age != '0) && (r_entry.age > i_ctl.victim_age);
        end
        r_entry <= n_entry;
    end

    assign o_any   = i_occupied & r_entry.runnable & ~r_entry.pinned & r_age_ok;
    assign w_hit   = o_any & (r_entry.in_exec | i_ctl.nonexec);
    assign w_sel   = i_ctl.steal ? w_hit : (i_head & i_occupied);
    assign o_take  = w_sel & ~i_found;
    assign o_found = i_found | w_sel;
    assign o_entry = r_entry;

    always_comb begin
        priority if (i_write) begin
            n_entry = i_new;
        end else if (i_ctl.remove && o_found) begin
            n_entry = i_next;
        end else begin
            n_entry = r_entry;
        end
    end

endmodule

FILE: src/run_queue_with_steal_top.sv
// ----------------------------------------------------------------------------
// run_queue_with_steal_top: fifo run queue with work stealing
// a row of slot cells in arrival order; enqueue, dequeue and steal of the
// first eligible entry, with the gap closed by a one-place shift
// ----------------------------------------------------------------------------
//  channel    dir  handshake           content
//  i_cmd      in   valid/ready         command, task attributes, allow_nonexec
//  o_rsp      out  valid/ready         status, removed tag/age, counts
//  i_cfg_*    in   write enable only   victim_age
//
//  the accept cycle latches a request and lets every cell take its age
//  test; in S_EXEC the find chain runs across the cells and the shift
//  commits; the next request is taken once the block is back in S_IDLE.
//  reset clears the counts, victim_age and the response valid flag and
//  holds i_cmd not ready; slot contents are left as they are and are only
//  read below the fill count.
//  a stalled response holds the commit cycle until the register frees up.
// ----------------------------------------------------------------------------
module run_queue_with_steal_top #(
    parameter int QUEUE_DEPTH = rqs_pkg::QUEUE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    rqs_stream_if.sink               i_cmd,
    rqs_stream_if.source             o_rsp,
    input  logic                     i_cfg_we,
    input  logic [rqs_pkg::AGE_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [rqs_pkg::AGE_W-1:0] r_victim_age;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [CNT_W-1:0]          r_steal_total;
    logic [CNT_W-1:0]          n_steal_total;

    // latched request
    rqs_pkg::t_cmd             r_cmd;
    rqs_pkg::t_entry           r_new_entry;
    logic                      r_nonexec;

    // response register
    logic                      r_out_valid;
    rqs_pkg::t_out_item        r_out;
    rqs_pkg::t_out_item        n_out;

    // cell row wiring
    rqs_pkg::t_cell_ctl        w_ctl;
    rqs_pkg::t_entry           w_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]      w_found;
    logic [QUEUE_DEPTH-1:0]    w_take;
    logic [QUEUE_DEPTH-1:0]    w_any;
    rqs_pkg::t_entry           w_rm_entry;
    logic                      w_rm_any;

    logic w_accept;
    logic w_finish;
    logic w_enq_ok;
    logic w_remove_ok;
    logic w_new_elig;

    // no transfer is taken while reset is held
    assign i_cmd.ready   = i_rst_n && (r_state == S_IDLE);
    assign w_accept      = i_cmd.valid && i_cmd.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // commit once the response register can take the result
    assign w_finish = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    assign w_ctl.capture    = w_accept;
    assign w_ctl.remove     = w_finish && w_remove_ok;
    assign w_ctl.steal      = (r_cmd == rqs_pkg::CMD_STEAL);
    assign w_ctl.nonexec    = r_nonexec;
    assign w_ctl.victim_age = r_victim_age;

    // find chain: the first selected cell starts the shift for itself and all
    // cells behind it
    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        rqs_pkg::t_entry w_next;

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = r_new_entry;
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end

        rqs_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occupied (CNT_W'(g) < r_count),
            .i_head     (g == 0),
            .i_write    (w_finish && w_enq_ok && (r_count == CNT_W'(g))),
            .i_new      (r_new_entry),
            .i_next     (w_next),
            .i_found    (w_found[g]),
            .o_found    (w_found[g+1]),
            .o_take     (w_take[g]),
            .o_any      (w_any[g]),
            .o_entry    (w_entry[g])
        );
    end

    // one-hot pick of the removed entry
    always_comb begin
        w_rm_entry = '0;
        w_rm_any   = 1'b0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (w_take[k]) begin
                w_rm_entry = w_rm_entry | w_entry[k];
            end
            w_rm_any = w_rm_any | (w_take[k] & w_any[k]);
        end
    end

    assign w_new_elig = r_new_entry.runnable && !r_new_entry.pinned &&
                        (r_new_entry.age != '0) && (r_new_entry.age > r_victim_age);

    // result and count update for the current request
    always_comb begin
        n_count       = r_count;
        n_steal_total = r_steal_total;
        w_enq_ok      = 1'b0;
        w_remove_ok   = 1'b0;
        n_out         = '0;
        n_out.status  = rqs_pkg::ST_MISS;
        unique case (r_cmd)
            rqs_pkg::CMD_ENQUEUE: begin
                if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                    n_out.status = rqs_pkg::ST_FULL;
                end else begin
                    w_enq_ok     = 1'b1;
                    n_count      = r_count + 1'b1;
                    n_out.status = rqs_pkg::ST_DONE;
                    if (w_new_elig && (r_steal_total < CNT_W'(QUEUE_DEPTH))) begin
                        n_steal_total = r_steal_total + 1'b1;
                    end
                end
            end
            rqs_pkg::CMD_DEQUEUE: begin
                if (r_count != '0) begin
                    w_remove_ok = 1'b1;
                    n_count     = r_count - 1'b1;
                    if (w_rm_any && (r_steal_total != '0)) begin
                        n_steal_total = r_steal_total - 1'b1;
                    end
                end
            end
            rqs_pkg::CMD_STEAL: begin
                // empty count misses without a scan
                if ((r_steal_total != '0) && w_found[QUEUE_DEPTH]) begin
                    w_remove_ok   = 1'b1;
                    n_count       = r_count - 1'b1;
                    n_steal_total = r_steal_total - 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (w_remove_ok) begin
            n_out.status      = rqs_pkg::ST_DONE;
            n_out.removed_tag = w_rm_entry.tag;
            n_out.removed_age = w_rm_entry.age;
        end
        n_out.stealable_count = rqs_pkg::OUT_CNT_W'(n_steal_total);
        n_out.occupancy       = rqs_pkg::OUT_CNT_W'(n_count);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_steal_total <= '0;
            r_victim_age  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_victim_age <= i_cfg_data;
            end
            if (w_finish) begin
                r_count       <= n_count;
                r_steal_total <= n_steal_total;
                r_out_valid   <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd                <= rqs_pkg::t_cmd'(i_cmd.payload.command);
            r_new_entry.tag      <= i_cmd.payload.task_tag;
            r_new_entry.runnable <= i_cmd.payload.is_runnable;
            r_new_entry.pinned   <= i_cmd.payload.is_pinned;
            r_new_entry.in_exec  <= i_cmd.payload.is_in_exec;
            r_new_entry.age      <= i_cmd.payload.age_cycles;
            r_nonexec            <= i_cmd.payload.allow_nonexec;
        end
        if (w_finish) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: run queue with work stealing, self-checking bench
// drives enqueue, dequeue, steal and the unused command code into the block,
// predicts every response from a private copy of the queue and the counts,
// and checks each response field by field across several victim_age values
// ----------------------------------------------------------------------------
module tb;

    // unused command code, the block must answer it with a miss
    localparam logic [rqs_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;

    localparam int RESET_CYCLES = 11;
    // pause after the last response before a register write or the end
    localparam int SETTLE_CYCLES = 6;
    // cycles with no transfer or register write before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int REPORT_MAX = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [rqs_pkg::AGE_W-1:0] cfg_data = '0;

    // command and response channels, payload driven from plain variables
    rqs_stream_if #(.T_PAYLOAD(rqs_pkg::t_in_item)) cmd_if ();
    rqs_stream_if #(.T_PAYLOAD(rqs_pkg::t_out_item)) rsp_if ();

    logic cmd_valid = 1'b0;
    rqs_pkg::t_in_item cmd_item = '0;
    logic rsp_ready = 1'b0;

    assign cmd_if.valid = cmd_valid;
    assign cmd_if.payload = cmd_item;
    assign rsp_if.ready = rsp_ready;

    run_queue_with_steal_top #(
        .QUEUE_DEPTH(rqs_pkg::QUEUE_DEPTH)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cmd(cmd_if),
        .o_rsp(rsp_if),
        .i_cfg_we(cfg_we),
        .i_cfg_data(cfg_data)
    );

    // --------------------------------------------------------------------
    // shadow run queue: entries in arrival order, head at index 0
    // --------------------------------------------------------------------
    rqs_pkg::t_entry shadow_slots[$];
    int shadow_steal_cnt = 0;
    logic [rqs_pkg::AGE_W-1:0] shadow_victim_age = '0;

    // commands waiting for the driver, responses waiting for the dut
    rqs_pkg::t_in_item pending_cmd_q[$];
    rqs_pkg::t_out_item expected_rsp_q[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_responses = 0;
    int n_fail = 0;
    int n_settings = 0;
    int n_steal_hit = 0;
    int n_steal_miss = 0;
    int n_full = 0;
    int n_deq_empty = 0;
    int peak_fill = 0;

    // idling control, set for the closing stretch of the run to turn idling off
    logic no_idle = 1'b0;
    int cmd_gap = 0;
    int rsp_gap = 0;
    int quiet_cycles = 0;
    rqs_pkg::t_out_item rsp_want;

    // an entry can be stolen when runnable, unpinned, in exec unless
    // non-exec stealing is allowed, and older than the victim age
    function automatic logic can_steal(rqs_pkg::t_entry e, logic nonexec);
        return e.runnable && !e.pinned && (e.in_exec || nonexec) &&
               (e.age != '0) && (e.age > shadow_victim_age);
    endfunction

    // applies one command to the shadow queue and returns its response
    function automatic rqs_pkg::t_out_item predict_rsp(rqs_pkg::t_in_item c);
        rqs_pkg::t_out_item r;
        rqs_pkg::t_entry e;
        int hit;
        r = '0;
        r.status = rqs_pkg::ST_MISS;
        hit = -1;
        case (c.command)
            rqs_pkg::CMD_ENQUEUE: begin
                if (shadow_slots.size() >= rqs_pkg::QUEUE_DEPTH) begin
                    r.status = rqs_pkg::ST_FULL;
                    n_full++;
                end else begin
                    e.tag = c.task_tag;
                    e.runnable = c.is_runnable;
                    e.pinned = c.is_pinned;
                    e.in_exec = c.is_in_exec;
                    e.age = c.age_cycles;
                    shadow_slots.push_back(e);
                    if (can_steal(e, 1'b1) && shadow_steal_cnt < rqs_pkg::QUEUE_DEPTH)
                        shadow_steal_cnt++;
                    r.status = rqs_pkg::ST_DONE;
                end
            end
            rqs_pkg::CMD_DEQUEUE: begin
                if (shadow_slots.size() > 0) begin
                    e = shadow_slots.pop_front();
                    // judged against the victim age in force now
                    if (can_steal(e, 1'b1) && shadow_steal_cnt > 0)
                        shadow_steal_cnt--;
                    r.status = rqs_pkg::ST_DONE;
                    r.removed_tag = e.tag;
                    r.removed_age = e.age;
                end else begin
                    n_deq_empty++;
                end
            end
            rqs_pkg::CMD_STEAL: begin
                // a zero count misses at once, without a scan
                if (shadow_steal_cnt != 0) begin
                    for (int i = 0; i < shadow_slots.size(); i++) begin
                        if (hit < 0 && can_steal(shadow_slots[i], c.allow_nonexec))
                            hit = i;
                    end
                end
                if (hit >= 0) begin
                    e = shadow_slots[hit];
                    shadow_slots.delete(hit);
                    shadow_steal_cnt--;
                    r.status = rqs_pkg::ST_DONE;
                    r.removed_tag = e.tag;
                    r.removed_age = e.age;
                    n_steal_hit++;
                end else begin
                    n_steal_miss++;
                end
            end
            default: ;
        endcase
        if (shadow_slots.size() > peak_fill)
            peak_fill = shadow_slots.size();
        r.stealable_count = rqs_pkg::OUT_CNT_W'(shadow_steal_cnt);
        r.occupancy = rqs_pkg::OUT_CNT_W'(shadow_slots.size());
        return r;
    endfunction

    function automatic rqs_pkg::t_in_item make_cmd(
        logic [rqs_pkg::CMD_W-1:0] op, logic [rqs_pkg::TAG_W-1:0] tag,
        logic run, logic pin, logic in_exec,
        logic [rqs_pkg::AGE_W-1:0] age, logic nonexec);
        rqs_pkg::t_in_item c;
        c.command = op;
        c.task_tag = tag;
        c.is_runnable = run;
        c.is_pinned = pin;
        c.is_in_exec = in_exec;
        c.age_cycles = age;
        c.allow_nonexec = nonexec;
        return c;
    endfunction

    task automatic queue_cmd(input rqs_pkg::t_in_item c);
        pending_cmd_q.push_back(c);
        n_queued++;
    endtask

    // every queued command accepted and every response back, then a pause
    task automatic wait_drained();
        do
            @(posedge clk);
        while (n_accepted != n_queued || expected_rsp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called with the block idle, so the shadow copy can switch here
    task automatic set_victim_age(input logic [rqs_pkg::AGE_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        shadow_victim_age = v;
        n_settings++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // --------------------------------------------------------------------
    // clock
    // --------------------------------------------------------------------
    initial begin
        forever #5 clk = ~clk;
    end

    // --------------------------------------------------------------------
    // driver: presents pending commands, holds valid until the transfer,
    // inserts random gaps between commands
    // --------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_valid <= 1'b0;
            cmd_gap <= 0;
        end else begin
            // a transfer here: the command takes effect in the shadow queue
            if (cmd_valid && cmd_if.ready) begin
                expected_rsp_q.push_back(predict_rsp(cmd_item));
                n_accepted++;
            end
            // channel free for the next command
            if (!cmd_valid || cmd_if.ready) begin
                if (cmd_gap != 0) begin
                    cmd_gap <= cmd_gap - 1;
                    cmd_valid <= 1'b0;
                end else if (pending_cmd_q.size() == 0) begin
                    cmd_valid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 15) == 0) begin
                    // a random gap, this one included
                    cmd_gap <= $urandom_range(0, 14);
                    cmd_valid <= 1'b0;
                end else begin
                    cmd_item <= pending_cmd_q.pop_front();
                    cmd_valid <= 1'b1;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // monitor: random backpressure on responses, checks each transfer
    // against the oldest prediction
    // --------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            rsp_gap <= 0;
        end else begin
            if (rsp_if.valid && rsp_ready) begin
                n_responses++;
                if (expected_rsp_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= REPORT_MAX)
                        $display("response with nothing predicted: st %0d tag %0d age %0d",
                                 rsp_if.payload.status, rsp_if.payload.removed_tag,
                                 rsp_if.payload.removed_age);
                end else begin
                    rsp_want = expected_rsp_q.pop_front();
                    if (rsp_if.payload.status !== rsp_want.status ||
                        rsp_if.payload.removed_tag !== rsp_want.removed_tag ||
                        rsp_if.payload.removed_age !== rsp_want.removed_age ||
                        rsp_if.payload.stealable_count !== rsp_want.stealable_count ||
                        rsp_if.payload.occupancy !== rsp_want.occupancy) begin
                        n_fail++;
                        if (n_fail <= REPORT_MAX) begin
                            $display("rsp %0d expected: st %0d tag %0d age %h cnt %0d occ %0d",
                                     n_responses, rsp_want.status, rsp_want.removed_tag,
                                     rsp_want.removed_age, rsp_want.stealable_count,
                                     rsp_want.occupancy);
                            $display("rsp %0d actual:   st %0d tag %0d age %h cnt %0d occ %0d",
                                     n_responses, rsp_if.payload.status,
                                     rsp_if.payload.removed_tag, rsp_if.payload.removed_age,
                                     rsp_if.payload.stealable_count,
                                     rsp_if.payload.occupancy);
                        end
                    end
                end
            end
            // random stall bursts
            if (rsp_gap != 0) begin
                rsp_gap <= rsp_gap - 1;
                rsp_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 15) == 0) begin
                rsp_gap <= $urandom_range(0, 14);
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // --------------------------------------------------------------------
    // watchdog: too long without any transfer or register write
    // --------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if ((cmd_valid && cmd_if.ready) || (rsp_if.valid && rsp_ready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("no transfer for %0d cycles, %0d responses outstanding",
                         quiet_cycles, expected_rsp_q.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // --------------------------------------------------------------------
    // stimulus and end of run
    // --------------------------------------------------------------------
    initial begin
        logic [63:0] rnd;
        rqs_pkg::t_in_item c;
        logic [rqs_pkg::AGE_W-1:0] va;
        int n_phase;
        int enq_left;
        int mix_left;
        int pick;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, victim_age still at its reset value of zero
        // empty queue: dequeue misses, steal misses on a zero count,
        // and the unused command code is answered with a miss
        queue_cmd(make_cmd(rqs_pkg::CMD_DEQUEUE, 8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b0));
        queue_cmd(make_cmd(rqs_pkg::CMD_STEAL, 8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b1));
        queue_cmd(make_cmd(CMD_RESERVED, 8'hFF, 1'b1, 1'b1, 1'b1, '1, 1'b1));
        // fill to the top: one not runnable, one pinned, one aged zero,
        // one at full age; only the back half is in exec
        for (int i = 0; i < rqs_pkg::QUEUE_DEPTH; i++) begin
            // count is nonzero but nothing is in exec yet: scan misses
            if (i == rqs_pkg::QUEUE_DEPTH / 2)
                queue_cmd(make_cmd(rqs_pkg::CMD_STEAL, 8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b0));
            queue_cmd(make_cmd(rqs_pkg::CMD_ENQUEUE, rqs_pkg::TAG_W'(i * 17), i != 1, i == 2,
                               i >= rqs_pkg::QUEUE_DEPTH / 2,
                               (i == 3) ? '0 : (i == 4) ? '1 : rqs_pkg::AGE_W'(i + 1),
                               1'b0));
        end
        // refused on a full queue
        queue_cmd(make_cmd(rqs_pkg::CMD_ENQUEUE, 8'hAA, 1'b1, 1'b0, 1'b1, 32'd99, 1'b1));
        // in-exec steal from the middle, then non-exec steal, then the head
        queue_cmd(make_cmd(rqs_pkg::CMD_STEAL, 8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b0));
        queue_cmd(make_cmd(rqs_pkg::CMD_STEAL, 8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b1));
        queue_cmd(make_cmd(rqs_pkg::CMD_DEQUEUE, 8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b0));
        wait_drained();

        // random part: each phase runs under its own victim_age, with the
        // queue contents carried over so the count can drift
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: va = '1;
                1: va = '0;
                2: va = rqs_pkg::AGE_W'($urandom_range(1, 40));
                3: va = $urandom();
                4: va = 32'hFFFF_FFF0;
                default: va = '0;
            endcase
            // closing stretch runs with no idling on either side
            if (p == PHASES - 1)
                no_idle = 1'b1;
            set_victim_age(va);

            n_phase = 0;
            while (n_phase < ITEMS_PER_PHASE) begin
                // a burst of enqueues, then a mix that drains the queue
                enq_left = $urandom_range(1, 18);
                mix_left = $urandom_range(1, 20);
                while (enq_left + mix_left > 0) begin
                    rnd = {$urandom(), $urandom()};
                    c = rnd[$bits(rqs_pkg::t_in_item)-1:0];
                    if (enq_left > 0) begin
                        c.command = rqs_pkg::CMD_ENQUEUE;
                        enq_left--;
                    end else begin
                        pick = $urandom_range(0, 19);
                        if (pick == 0)
                            c.command = CMD_RESERVED;
                        else if (pick <= 6)
                            c.command = rqs_pkg::CMD_DEQUEUE;
                        else if (pick <= 15)
                            c.command = rqs_pkg::CMD_STEAL;
                        else
                            c.command = rqs_pkg::CMD_ENQUEUE;
                        mix_left--;
                    end
                    if (c.command == rqs_pkg::CMD_ENQUEUE) begin
                        // mostly stealable tasks, ages clustered on the threshold
                        c.is_runnable = $urandom_range(0, 6) != 0;
                        c.is_pinned = $urandom_range(0, 6) == 0;
                        case ($urandom_range(0, 9))
                            0: c.age_cycles = '0;
                            1: c.age_cycles = '1;
                            2: c.age_cycles = shadow_victim_age;
                            3: c.age_cycles = shadow_victim_age + 1;
                            4: c.age_cycles = shadow_victim_age - 1;
                            5, 6: c.age_cycles = rqs_pkg::AGE_W'($urandom_range(1, 64));
                            default: ;
                        endcase
                    end
                    queue_cmd(c);
                    n_phase++;
                end
            end
            wait_drained();
        end

        // any prediction still waiting was never answered
        if (expected_rsp_q.size() != 0) begin
            $display("%0d responses never arrived", expected_rsp_q.size());
            n_fail += expected_rsp_q.size();
        end

        $display("ran %0d commands and %0d responses over %0d victim_age writes, peak %0d",
                 n_accepted, n_responses, n_settings, peak_fill);
        $display("steals hit %0d missed %0d, full refusals %0d, empty dequeues %0d",
                 n_steal_hit, n_steal_miss, n_full, n_deq_empty);
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d failures", n_fail);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
